[rtl/aes_pkg.sv]
// aes_pkg: shared constants, s-box table and round helper functions for the aes-128 encrypt unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

    localparam int ROUND_COUNT = 10;
    localparam int BLOCK_W     = 128;
    localparam int HALF_W      = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;

    localparam logic [7:0] RCON_FIRST = 8'h01;
    localparam logic [7:0] GF_POLY    = 8'h1b;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [ROUND_COUNT:1][BLOCK_W-1:0] t_rk_arr;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte i of the state sits at bits [127-8i -: 8]
    function automatic t_block next_round_key(input t_block k, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        next_round_key = {w0, w1, w2, w3};
    endfunction

    function automatic t_block round_fn(input t_block s, input t_block k, input logic last);
        logic [7:0] a [16];
        logic [7:0] t [16];
        logic [7:0] m [16];
        t_block r;
        for (int i = 0; i < 16; i++) begin
            a[i] = s[BLOCK_W-1-8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int rw = 0; rw < 4; rw++) begin
                t[4*c+rw] = SBOX[a[4*((c+rw)%4)+rw]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            m[4*c]   = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            m[4*c+1] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
            m[4*c+2] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
            m[4*c+3] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
        end
        for (int i = 0; i < 16; i++) begin
            r[BLOCK_W-1-8*i -: 8] = last ? t[i] : m[i];
        end
        round_fn = r ^ k;
    endfunction

endpackage
`default_nettype wire

[rtl/aes_key_exp.sv]
// aes_key_exp: key registers and iterative key expansion, one round key per cycle
// depends on aes_pkg
`timescale 1ns / 1ps
`default_nettype none
module aes_key_exp
    import aes_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_wr_index,
    input  wire logic [HALF_W-1:0]    i_wr_data,
    output logic [BLOCK_W-1:0]        o_rk0,
    output t_rk_arr                   o_rk,
    output logic                      o_ready
);

    logic [HALF_W-1:0]  r_key_hi, n_key_hi;
    logic [HALF_W-1:0]  r_key_lo, n_key_lo;
    logic               r_busy, n_busy;
    logic [3:0]         r_cnt, n_cnt;
    logic [7:0]         r_rcon, n_rcon;
    t_block             r_prev, n_prev;
    t_rk_arr            r_rk;
    t_block             w_next;
    logic               w_hit;

    assign w_next = next_round_key(r_prev, r_rcon);
    assign w_hit  = i_wr_en && (i_wr_index == CFG_KEY_HIGH || i_wr_index == CFG_KEY_LOW);

    always_comb begin
        n_key_hi = r_key_hi;
        n_key_lo = r_key_lo;
        n_busy   = r_busy;
        n_cnt    = r_cnt;
        n_rcon   = r_rcon;
        n_prev   = r_prev;
        if (w_hit) begin
            if (i_wr_index == CFG_KEY_HIGH) begin
                n_key_hi = i_wr_data;
            end else begin
                n_key_lo = i_wr_data;
            end
            n_busy = 1'b1;
            n_cnt  = 4'd1;
            n_rcon = RCON_FIRST;
            n_prev = {n_key_hi, n_key_lo};
        end else if (r_busy) begin
            n_prev = w_next;
            n_rcon = xtime(r_rcon);
            n_cnt  = r_cnt + 4'd1;
            if (r_cnt == 4'(ROUND_COUNT)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_busy   <= 1'b1;
            r_cnt    <= 4'd1;
            r_rcon   <= RCON_FIRST;
            r_prev   <= '0;
        end else begin
            r_key_hi <= n_key_hi;
            r_key_lo <= n_key_lo;
            r_busy   <= n_busy;
            r_cnt    <= n_cnt;
            r_rcon   <= n_rcon;
            r_prev   <= n_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !w_hit) begin
            r_rk[r_cnt] <= w_next;
        end
    end

    assign o_rk0   = {r_key_hi, r_key_lo};
    assign o_rk    = r_rk;
    assign o_ready = !r_busy;

endmodule
`default_nettype wire

[rtl/aes_round.sv]
// aes_round: one registered cipher round stage with its own valid bit and backpressure
// depends on aes_pkg
`timescale 1ns / 1ps
`default_nettype none
module aes_round
    import aes_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_last,
    input  wire t_block i_key,
    input  wire logic   i_valid,
    input  wire t_block i_state,
    output logic        o_ready,
    output logic        o_valid,
    output t_block      o_state,
    input  wire logic   i_ready
);

    logic   r_valid;
    t_block r_state;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_state <= round_fn(i_state, i_key, i_last);
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule
`default_nettype wire

[rtl/aes128_block_encrypt_unit.sv]
// aes128_block_encrypt_unit: top level, aes-128 ecb encryption with an unrolled round pipeline
// depends on aes_pkg, aes_key_exp, aes_round
//
// usage
//   cfg channel: index 0 writes key bits 127:64, index 1 writes key bits 63:0; other
//   indexes are ignored. every key write restarts key expansion, which produces
//   one round key per cycle from the shared expansion step; o_s_tready stays low meanwhile.
//   after reset the all-zero key is expanded the same way, so the first item can be
//   taken only once that expansion has finished.
//   slave stream: tdata[63:0] = block_high, tdata[127:64] = block_low.
//   master stream: tdata[63:0] = cipher_high, tdata[127:64] = cipher_low.
//   pipeline: the initial key add register plus 10 round stages, 11 registers in all,
//   lie between the accept edge and o_m_tvalid.
//   throughput: one item per cycle while the receiver does not stall; each stage holds its own valid bit.
//   when the receiver stalls, stages fill up behind the output register and bubbles
//   are squeezed out; outside key expansion, input is refused only once every stage holds an item.
//   keys may be written only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none
module aes128_block_encrypt_unit
    import aes_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [HALF_W-1:0]    i_cfg_data,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [BLOCK_W-1:0]   i_s_tdata,  // block_high, block_low
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [BLOCK_W-1:0]        o_m_tdata   // cipher_high, cipher_low
);

    logic    w_key_ready;
    t_block  w_rk0;
    t_rk_arr w_rk;

    logic    r_v0;
    t_block  r_s0;

    logic [ROUND_COUNT:0] w_valid;
    logic [ROUND_COUNT:0] w_ready;
    t_block               w_state [ROUND_COUNT+1];
    logic                 w_stage0_ready;

    assign o_cfg_ready = 1'b1;

    aes_key_exp u_key_exp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_rk0      (w_rk0),
        .o_rk       (w_rk),
        .o_ready    (w_key_ready)
    );

    // initial add round key
    assign w_stage0_ready = !r_v0 || w_ready[0];
    assign o_s_tready     = w_key_ready && w_stage0_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_stage0_ready) begin
            r_v0 <= i_s_tvalid && w_key_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_s0 <= {i_s_tdata[HALF_W-1:0], i_s_tdata[BLOCK_W-1:HALF_W]} ^ w_rk0;
        end
    end

    assign w_valid[0] = r_v0;
    assign w_state[0] = r_s0;

    for (genvar g = 1; g <= ROUND_COUNT; g++) begin : g_round
        aes_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_last  (g == ROUND_COUNT),
            .i_key   (w_rk[g]),
            .i_valid (w_valid[g-1]),
            .i_state (w_state[g-1]),
            .o_ready (w_ready[g-1]),
            .o_valid (w_valid[g]),
            .o_state (w_state[g]),
            .i_ready (w_ready[g])
        );
    end

    assign w_ready[ROUND_COUNT] = i_m_tready;
    assign o_m_tvalid           = w_valid[ROUND_COUNT];
    assign o_m_tdata = {w_state[ROUND_COUNT][HALF_W-1:0],
                        w_state[ROUND_COUNT][BLOCK_W-1:HALF_W]};

    property p_key_write_blocks_input;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && (i_cfg_index == CFG_KEY_HIGH || i_cfg_index == CFG_KEY_LOW))
        |=> !o_s_tready;
    endproperty
    a_key_write_blocks_input: assert property (p_key_write_blocks_input)
        else $error("input accepted right after a key write");

    property p_accept_needs_keys;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |-> w_key_ready;
    endproperty
    a_accept_needs_keys: assert property (p_accept_needs_keys)
        else $error("item accepted before key expansion finished");

    property p_out_holds_on_stall;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata));
    endproperty
    a_out_holds_on_stall: assert property (p_out_holds_on_stall)
        else $error("output item changed while stalled");

endmodule
`default_nettype wire

[verif/aes128_block_encrypt_unit_tb.sv]
// aes128_block_encrypt_unit_tb: checks aes-128 ecb encryption on the stream ports against
// a behavioral cipher model, with random idling, key changes and a directed table first
// depends on aes_pkg and aes128_block_encrypt_unit
`timescale 1ns / 1ps
module aes128_block_encrypt_unit_tb;
    import aes_pkg::*;

    localparam int N_RANDOM = 1850;
    localparam int WATCHDOG = 20000;
    localparam int DRAIN    = 40;

    typedef struct {
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [63:0] pt_hi;
        logic [63:0] pt_lo;
        logic        has_ct;
        logic [63:0] ct_hi;
        logic [63:0] ct_lo;
    } vec_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [HALF_W-1:0]    i_cfg_data;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [BLOCK_W-1:0]   i_s_tdata;  // block_high, block_low
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [BLOCK_W-1:0]   o_m_tdata;  // cipher_high, cipher_low

    logic [63:0]  cur_key_hi;
    logic [63:0]  cur_key_lo;
    logic [127:0] cipher_q[$];
    int           err_count;
    int           idle_cycles;
    vec_t         dir_tab[16];

    logic [7:0] sb [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    aes128_block_encrypt_unit dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] gf_dbl(input logic [7:0] b);
        gf_dbl = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // returns {cipher_low, cipher_high} as on tdata
    function automatic logic [127:0] encrypt_block(input logic [63:0] kh, input logic [63:0] kl,
                                                   input logic [63:0] ph, input logic [63:0] pl);
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0]  rc;
        logic [7:0]  s [16];
        logic [7:0]  u [16];
        logic [7:0]  a0, a1, a2, a3;
        logic [63:0] ch, cl;
        w[0] = kh[63:32];
        w[1] = kh[31:0];
        w[2] = kl[63:32];
        w[3] = kl[31:0];
        rc = 8'h01;
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {sb[t[31:24]], sb[t[23:16]], sb[t[15:8]], sb[t[7:0]]} ^ {rc, 24'h0};
                rc = gf_dbl(rc);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int i = 0; i < 8; i++) begin
            s[i]   = ph[63-8*i -: 8];
            s[8+i] = pl[63-8*i -: 8];
        end
        for (int rnd = 0; rnd <= ROUND_COUNT; rnd++) begin
            if (rnd > 0) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        u[4*c+r] = sb[s[4*((c+r)%4)+r]];
                s = u;
                if (rnd < ROUND_COUNT) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                        s[4*c]   = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
                        s[4*c+1] = a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3;
                        s[4*c+2] = a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3;
                        s[4*c+3] = gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3);
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    s[4*c+r] ^= w[rnd*4+c][31-8*r -: 8];
        end
        for (int i = 0; i < 8; i++) begin
            ch[63-8*i -: 8] = s[i];
            cl[63-8*i -: 8] = s[8+i];
        end
        encrypt_block = {cl, ch};
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            default: v = {$urandom(), $urandom()};
        endcase
        rand64 = v;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic wait_drained();
        while (cipher_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_KEY_HIGH) cur_key_hi = val;
        else if (idx == CFG_KEY_LOW) cur_key_lo = val;
    endtask

    task automatic set_key(input logic [63:0] kh, input logic [63:0] kl);
        wait_drained();
        repeat (DRAIN) @(posedge i_clk);
        write_key(CFG_KEY_HIGH, kh);
        write_key(CFG_KEY_LOW, kl);
    endtask

    task automatic send_block(input logic [63:0] ph, input logic [63:0] pl);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {pl, ph};
        do @(posedge i_clk); while (!o_s_tready);
        cipher_q.push_back(encrypt_block(cur_key_hi, cur_key_lo, ph, pl));
    endtask

    // receiver: random stalls, compare against oldest expectation
    int rx_wait;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (cipher_q.size() == 0) begin
                    $display("%0t: unexpected output item %h", $realtime, o_m_tdata);
                    err_count++;
                end else begin
                    if (o_m_tdata[63:0] !== cipher_q[0][63:0])
                        report_mismatch("cipher_high", o_m_tdata[63:0], cipher_q[0][63:0]);
                    if (o_m_tdata[127:64] !== cipher_q[0][127:64])
                        report_mismatch("cipher_low", o_m_tdata[127:64], cipher_q[0][127:64]);
                    void'(cipher_q.pop_front());
                end
                rx_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [63:0] kh, kl;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        err_count    = 0;
        idle_cycles  = 0;
        cur_key_hi   = '0;
        cur_key_lo   = '0;

        // zero key after reset, fips-197 vectors, extremes
        dir_tab[0]  = '{64'h0, 64'h0, 64'h0, 64'h0, 1'b1,
                        64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e};
        dir_tab[1]  = '{64'h0, 64'h0, '1, '1, 1'b0, 64'h0, 64'h0};
        dir_tab[2]  = '{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                        64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
                        64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a};
        dir_tab[3]  = '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
                        64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b1,
                        64'h3925841d02dc09fb, 64'hdc118597196a0b32};
        dir_tab[4]  = '{'1, '1, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0};
        dir_tab[5]  = '{'1, '1, '1, '1, 1'b0, 64'h0, 64'h0};
        dir_tab[6]  = '{'1, 64'h0, 64'h8000000000000000, 64'h1, 1'b0, 64'h0, 64'h0};
        dir_tab[7]  = '{64'h0, '1, 64'h1, 64'h8000000000000000, 1'b0, 64'h0, 64'h0};
        for (int i = 8; i < 16; i++)
            dir_tab[i] = '{dir_tab[i-1].key_hi, dir_tab[i-1].key_lo,
                           64'h1 << (i * 8 - 1), ~(64'h1 << (i * 8 - 1)), 1'b0, 64'h0, 64'h0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].key_hi !== cur_key_hi || dir_tab[i].key_lo !== cur_key_lo) begin
                i_s_tvalid <= 1'b0;
                set_key(dir_tab[i].key_hi, dir_tab[i].key_lo);
            end
            send_block(dir_tab[i].pt_hi, dir_tab[i].pt_lo);
            if (dir_tab[i].has_ct
                && cipher_q[$] !== {dir_tab[i].ct_lo, dir_tab[i].ct_hi}) begin
                $display("%0t: model disagrees with known vector in row %0d", $realtime, i);
                err_count++;
            end
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 200 == 100) begin
                // a single half rewritten, the other half kept
                i_s_tvalid <= 1'b0;
                kh = rand64();
                kl = rand64();
                wait_drained();
                repeat (DRAIN) @(posedge i_clk);
                if ($urandom_range(0, 1)) write_key(CFG_KEY_HIGH, kh);
                else write_key(CFG_KEY_LOW, kl);
            end else if (n % 300 == 0) begin
                i_s_tvalid <= 1'b0;
                set_key(rand64(), rand64());
            end else if (n == 777) begin
                i_s_tvalid <= 1'b0;
                wait_drained();
            end
            send_block(rand64(), rand64());
        end
        i_s_tvalid   <= 1'b0;

        wait_drained();
        repeat (DRAIN) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
